@@ hdl/mif_pkg.sv @@
// Shared constants, payload types and saturation helpers for the multichannel IIR filter.
package mif_pkg;

    localparam int MAX_ORDER    = 3;
    localparam int MAX_CHANNELS = 8;

    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 24;
    localparam int CH_W      = 3;
    localparam int STATE_W   = 48;
    localparam int FRAC_BITS = 20;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int RND_W     = STATE_W + 2;
    localparam int YFULL_W   = RND_W - FRAC_BITS;

    localparam int COEF_COUNT = 2 * MAX_ORDER + 1;
    localparam int PADDR_W    = $clog2(COEF_COUNT) + 2;
    localparam int PIDX_W     = PADDR_W - 2;
    localparam int PDATA_W    = 32;

    localparam int CH_AW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int TAP_AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int ROW_W  = MAX_ORDER * STATE_W;

    localparam int REG_B0 = 0;
    localparam int REG_B1 = 1;
    localparam int REG_A1 = MAX_ORDER + 1;

    localparam logic signed [COEF_W-1:0] B0_RESET   = COEF_W'(1 << FRAC_BITS);
    localparam logic signed [RND_W-1:0]  ROUND_HALF = RND_W'(1 << (FRAC_BITS - 1));

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [CH_W-1:0]            channel;
    } mif_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic [CH_W-1:0]            out_channel;
    } mif_out_t;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic [YFULL_W-1:0] v);
        logic [YFULL_W-SAMPLE_W:0] top;
        top = v[YFULL_W-1:SAMPLE_W-1];
        if ((&top) || !(|top)) begin
            return v[SAMPLE_W-1:0];
        end else if (v[YFULL_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [STATE_W-1:0] sat_tap(input logic [RND_W-1:0] v);
        logic [RND_W-STATE_W:0] top;
        top = v[RND_W-1:STATE_W-1];
        if ((&top) || !(|top)) begin
            return v[STATE_W-1:0];
        end else if (v[RND_W-1]) begin
            return {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(STATE_W-1){1'b1}}};
        end
    endfunction

endpackage

@@ hdl/multichannel_iir_filter.sv @@
// Multichannel transposed direct form II IIR filter with per-channel tap memory.
// One beat at a time: a new beat is taken only in idle, after the previous result has
// left write-back, which waits on m_ready while an earlier result is still held;
// one coefficient multiplier pair steps through the taps, with one tap memory row per channel.
// Reset: synchronous active-low aresetn clears control, the per-channel valid bits
// (taps read as zero until written) and loads the coefficient reset values.
module multichannel_iir_filter
    import mif_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  mif_in_t            s_data,

    output logic               m_valid,
    input  logic               m_ready,
    output mif_out_t           m_data,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_YCALC = 6'b000100,
        ST_TMUL  = 6'b001000,
        ST_TADD  = 6'b010000,
        ST_WB    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic signed [COEF_W-1:0] b0_reg;
    logic signed [COEF_W-1:0] b_reg [MAX_ORDER];
    logic signed [COEF_W-1:0] a_reg [MAX_ORDER];

    logic [ROW_W-1:0]        mem [MAX_CHANNELS];
    logic [ROW_W-1:0]        mem_q_reg;
    logic [MAX_CHANNELS-1:0] vld_reg;
    logic                    rd_vld_reg;

    mif_in_t                    in_reg;
    logic                       ch_ok_reg;
    logic signed [PROD_W-1:0]   pb_reg, pa_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [STATE_W-1:0]  z_reg [MAX_ORDER];
    logic [TAP_AW-1:0]          tap_reg;

    logic     m_valid_reg;
    mif_out_t m_data_reg;

    logic                      s_accept, ch_ok, out_free, wb_fire, last_tap, cfg_wr;
    logic [CH_AW-1:0]          rd_addr, wr_addr;
    logic [PIDX_W-1:0]         pidx;
    logic signed [COEF_W-1:0]  mul_coef, rd_coef;
    logic signed [STATE_W-1:0] z_next;
    logic [RND_W-1:0]          y_rnd, t_sum;
    logic [ROW_W-1:0]          row_wr;

    // handshake and control
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign ch_ok    = (int'(s_data.channel) < MAX_CHANNELS);
    assign rd_addr  = CH_AW'(s_data.channel);
    assign wr_addr  = CH_AW'(in_reg.channel);
    assign out_free = !m_valid_reg || m_ready;
    assign wb_fire  = (state_reg == ST_WB) && out_free;
    assign last_tap = (tap_reg == TAP_AW'(MAX_ORDER - 1));

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // datapath
    assign mul_coef = (state_reg == ST_LOAD) ? b0_reg : b_reg[tap_reg];
    assign z_next   = last_tap ? '0 : z_reg[tap_reg + 1'b1];
    assign y_rnd    = RND_W'(pb_reg) + RND_W'(z_reg[0]) + ROUND_HALF;
    assign t_sum    = RND_W'(pb_reg) + RND_W'(z_next) - RND_W'(pa_reg);

    always_comb begin
        for (int i = 0; i < MAX_ORDER; i++) begin
            row_wr[i*STATE_W +: STATE_W] = z_reg[i];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ch_ok ? ST_LOAD : ST_WB;
                end
            end
            ST_LOAD:  state_next = ST_YCALC;
            ST_YCALC: state_next = ST_TMUL;
            ST_TMUL:  state_next = ST_TADD;
            ST_TADD:  state_next = last_tap ? ST_WB : ST_TMUL;
            ST_WB: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tap_reg     <= '0;
            m_valid_reg <= 1'b0;
            vld_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_YCALC) begin
                tap_reg <= '0;
            end else if (state_reg == ST_TADD && !last_tap) begin
                tap_reg <= tap_reg + 1'b1;
            end
            if (wb_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (wb_fire && ch_ok_reg) begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // tap memory, one row per channel
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mem_q_reg <= mem[rd_addr];
        end
        if (wb_fire && ch_ok_reg) begin
            mem[wr_addr] <= row_wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg     <= s_data;
            ch_ok_reg  <= ch_ok;
            rd_vld_reg <= vld_reg[rd_addr];
            y_reg      <= '0;
        end
        if (state_reg == ST_LOAD) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                z_reg[i] <= rd_vld_reg ? mem_q_reg[i*STATE_W +: STATE_W] : '0;
            end
        end
        if (state_reg == ST_LOAD || state_reg == ST_TMUL) begin
            pb_reg <= PROD_W'(mul_coef) * PROD_W'(in_reg.sample_in);
        end
        if (state_reg == ST_TMUL) begin
            pa_reg <= PROD_W'(a_reg[tap_reg]) * PROD_W'(y_reg);
        end
        if (state_reg == ST_YCALC) begin
            y_reg <= sat_sample(y_rnd[RND_W-1:FRAC_BITS]);
        end
        if (state_reg == ST_TADD) begin
            z_reg[tap_reg] <= sat_tap(t_sum);
        end
        if (wb_fire) begin
            m_data_reg.sample_out  <= y_reg;
            m_data_reg.out_channel <= in_reg.channel;
        end
    end

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign pidx   = paddr[PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg <= B0_RESET;
            for (int i = 0; i < MAX_ORDER; i++) begin
                b_reg[i] <= '0;
                a_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            if (pidx == PIDX_W'(REG_B0)) begin
                b0_reg <= pwdata[COEF_W-1:0];
            end
            for (int i = 0; i < MAX_ORDER; i++) begin
                if (pidx == PIDX_W'(REG_B1 + i)) begin
                    b_reg[i] <= pwdata[COEF_W-1:0];
                end
                if (pidx == PIDX_W'(REG_A1 + i)) begin
                    a_reg[i] <= pwdata[COEF_W-1:0];
                end
            end
        end
    end

    always_comb begin
        rd_coef = '0;
        if (pidx == PIDX_W'(REG_B0)) begin
            rd_coef = b0_reg;
        end
        for (int i = 0; i < MAX_ORDER; i++) begin
            if (pidx == PIDX_W'(REG_B1 + i)) begin
                rd_coef = b_reg[i];
            end
            if (pidx == PIDX_W'(REG_A1 + i)) begin
                rd_coef = a_reg[i];
            end
        end
    end

    assign prdata = {{(PDATA_W-COEF_W){rd_coef[COEF_W-1]}}, rd_coef};

    // checks
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("second beat accepted while an item is in flight");

    a_out_from_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_WB))
        else $error("result raised outside write-back");

    a_out_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_data.out_channel == in_reg.channel))
        else $error("result channel differs from accepted channel");

    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TMUL || state_reg == ST_TADD)
            |-> (int'(tap_reg) < MAX_ORDER))
        else $error("tap counter out of range");

endmodule
